@@ rtl/core/hsvpw_pkg.sv @@
// Package: shared types, constants and stage payloads of the HSV/RGB pixel writer.
package hsvpw_pkg;

   // Framebuffer geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 128;

   // Field and register widths
   localparam int COORD_W    = 16;
   localparam int HUE_W      = 15;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 13;
   localparam int AW_W       = 7;
   localparam int AH_W       = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   localparam logic [AW_W-1:0] AW_RESET = AW_W'(64);
   localparam logic [AH_W-1:0] AH_RESET = AH_W'(128);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_WIDTH  = 1'b0,
      CSR_ACTIVE_HEIGHT = 1'b1
   } csr_index_type;

   // Command codes
   localparam logic ACT_RGB = 1'b0;
   localparam logic ACT_HSV = 1'b1;

   // Hue geometry in 1/64 degree: one sector is 60 degrees
   localparam int HUE_SECTOR = 3840;
   localparam int HUE_PAIR   = 2 * HUE_SECTOR;
   localparam int K_W        = 12;
   localparam int T_W        = 13;

   // Product widths
   localparam int PROD_W = 16;
   localparam int NUM_W  = 28;
   localparam int M_W    = 20;
   localparam int Q15_W  = 16;

   // floor(n/255) for 16-bit n: (n * 32897) >> 23
   localparam int RECIP255       = 32897;
   localparam int RECIP255_SHIFT = 23;
   // floor(m/15) for 20-bit m: (m * 1118482) >> 24
   localparam int RECIP15        = 1118482;
   localparam int RECIP15_W      = 21;
   localparam int RECIP15_SHIFT  = 24;
   // 979200 = 256 * 15 * 255
   localparam int MID_PRE_SHIFT  = 8;

   // Which channel carries c+m (hi), x+m (mid) and m (lo); named first-second
   typedef enum logic [2:0] {
      SEC_R_G,   // r = hi,  g = mid, b = lo
      SEC_G_R,   // r = mid, g = hi,  b = lo
      SEC_G_B,   // r = lo,  g = hi,  b = mid
      SEC_B_G,   // r = lo,  g = mid, b = hi
      SEC_B_R,   // r = mid, g = lo,  b = hi
      SEC_R_B    // r = hi,  g = lo,  b = mid
   } sector_type;

   typedef struct packed {
      logic                       action;
      logic signed [COORD_W-1:0]  pixel_x;
      logic signed [COORD_W-1:0]  pixel_y;
      logic        [BYTE_W-1:0]   red_in;
      logic        [BYTE_W-1:0]   green_in;
      logic        [BYTE_W-1:0]   blue_in;
      logic        [HUE_W-1:0]    hue;
      logic        [BYTE_W-1:0]   saturation;
      logic        [BYTE_W-1:0]   brightness;
   } req_payload_type;

   typedef struct packed {
      logic                write_enable;
      logic [ADDR_W-1:0]   write_address;
      logic [BYTE_W-1:0]   red_out;
      logic [BYTE_W-1:0]   green_out;
      logic [BYTE_W-1:0]   blue_out;
   } rsp_payload_type;

   // Fields common to every pipeline stage
   typedef struct packed {
      logic                ok;
      logic [ADDR_W-1:0]   addr;
      logic                action;
      sector_type          sector;
      logic [BYTE_W-1:0]   hi;
      logic [BYTE_W-1:0]   red;
      logic [BYTE_W-1:0]   green;
      logic [BYTE_W-1:0]   blue;
   } common_type;

   typedef struct packed {
      common_type          c;
      logic [K_W-1:0]      k;
      logic [PROD_W-1:0]   vs;
      logic [PROD_W-1:0]   vns;
   } s1_type;

   typedef struct packed {
      common_type          c;
      logic [NUM_W-1:0]    num;
      logic [BYTE_W-1:0]   lo;
   } s2_type;

   typedef struct packed {
      common_type          c;
      logic [Q15_W-1:0]    q15;
      logic [BYTE_W-1:0]   lo;
   } s3_type;

endpackage

@@ rtl/core/hsvpw_req_if.sv @@
// Interface: pixel command channel (valid, ready, command payload).
interface hsvpw_req_if;
   import hsvpw_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/hsvpw_rsp_if.sv @@
// Interface: framebuffer write channel (valid, ready, write payload).
interface hsvpw_rsp_if;
   import hsvpw_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/hsv_rgb_pixel_writer_unit.sv @@
// Top level: pipelined HSV/RGB pixel writer with bounds check and address generation.
//
//   channel   | direction | handshake          | carries
//   ----------+-----------+--------------------+----------------------------------------
//   req_bus   | in        | valid/ready        | action, pixel_x/y, RGB bytes, HSV
//   rsp_bus   | out       | valid/ready        | write_enable, write_address, RGB bytes
//   csr_*     | in        | write enable only  | active_width (0), active_height (1)
//
// One transfer per cycle on both channels while the response side is ready. A request
// taken passes four register stages, one per dependent multiply (v*s, the numerator,
// then the reciprocal divides by 15 and by 255), the last of them the output register.
// Synchronous active-high reset clears the stage valid bits and loads the
// active size to 64 x 128. A stalled response freezes every stage at once, so
// no item is dropped or repeated; ready follows the output register's state.
module hsv_rgb_pixel_writer_unit (
   input  logic                                clock,
   input  logic                                reset,
   hsvpw_req_if.sink                           req_bus,
   hsvpw_rsp_if.source                         rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [hsvpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hsvpw_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import hsvpw_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [AW_W-1:0] active_width_ff, active_width_in;
   logic [AH_W-1:0] active_height_ff, active_height_in;

   always_comb begin
      active_width_in  = active_width_ff;
      active_height_in = active_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_WIDTH:  active_width_in  = csr_write_data[AW_W-1:0];
            CSR_ACTIVE_HEIGHT: active_height_in = csr_write_data[AH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= AW_RESET;
         active_height_ff <= AH_RESET;
      end else begin
         active_width_ff  <= active_width_in;
         active_height_ff <= active_height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances together unless the output
   // register holds a result that is not being taken.
   // ---------------------------------------------------------------------
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // ---------------------------------------------------------------------
   // Stage 1: bounds check, address, sector, triangle k, v*s and v*(255-s)
   // ---------------------------------------------------------------------
   s1_type             s1_ff, s1_in;
   logic [COORD_W-1:0] wlim, hlim;
   logic [HUE_W-1:0]   hue;
   logic [T_W-1:0]     hue_t;
   logic [BYTE_W-1:0]  sat, val;

   always_comb begin
      hue = req_bus.data.hue;
      sat = req_bus.data.saturation;
      val = req_bus.data.brightness;

      // Clamp the active size to the framebuffer
      wlim = (COORD_W'(active_width_ff) < COORD_W'(MAX_WIDTH)) ?
             COORD_W'(active_width_ff) : COORD_W'(MAX_WIDTH);
      hlim = (COORD_W'(active_height_ff) < COORD_W'(MAX_HEIGHT)) ?
             COORD_W'(active_height_ff) : COORD_W'(MAX_HEIGHT);

      s1_in.c.ok = !req_bus.data.pixel_x[COORD_W-1] && !req_bus.data.pixel_y[COORD_W-1]
                   && ($unsigned(req_bus.data.pixel_x) < wlim)
                   && ($unsigned(req_bus.data.pixel_y) < hlim);
      s1_in.c.addr = ADDR_W'(32'($unsigned(req_bus.data.pixel_x)) * 32'(MAX_HEIGHT)
                             + 32'($unsigned(req_bus.data.pixel_y)));
      s1_in.c.action = req_bus.data.action;
      s1_in.c.hi     = val;
      s1_in.c.red    = req_bus.data.red_in;
      s1_in.c.green  = req_bus.data.green_in;
      s1_in.c.blue   = req_bus.data.blue_in;

      // Sector and hue reduced mod two sectors; hue past 360 degrees
      // stays in the last sector
      if (32'(hue) < HUE_SECTOR) begin
         s1_in.c.sector = SEC_R_G;
         hue_t          = T_W'(hue);
      end else if (32'(hue) < HUE_PAIR) begin
         s1_in.c.sector = SEC_G_R;
         hue_t          = T_W'(hue);
      end else if (32'(hue) < 3 * HUE_SECTOR) begin
         s1_in.c.sector = SEC_G_B;
         hue_t          = T_W'(32'(hue) - HUE_PAIR);
      end else if (32'(hue) < 2 * HUE_PAIR) begin
         s1_in.c.sector = SEC_B_G;
         hue_t          = T_W'(32'(hue) - HUE_PAIR);
      end else if (32'(hue) < 5 * HUE_SECTOR) begin
         s1_in.c.sector = SEC_B_R;
         hue_t          = T_W'(32'(hue) - 2 * HUE_PAIR);
      end else begin
         s1_in.c.sector = SEC_R_B;
         if (32'(hue) < 3 * HUE_PAIR) begin
            hue_t = T_W'(32'(hue) - 2 * HUE_PAIR);
         end else if (32'(hue) < 4 * HUE_PAIR) begin
            hue_t = T_W'(32'(hue) - 3 * HUE_PAIR);
         end else begin
            hue_t = T_W'(32'(hue) - 4 * HUE_PAIR);
         end
      end

      s1_in.k = (32'(hue_t) >= HUE_SECTOR) ? K_W'(HUE_PAIR - 32'(hue_t)) : K_W'(hue_t);

      s1_in.vs  = PROD_W'(val) * PROD_W'(sat);
      s1_in.vns = PROD_W'(val) * PROD_W'(8'd255 - sat);
   end

   // ---------------------------------------------------------------------
   // Stage 2: numerator v*s*k + v*(255-s)*3840, and m = floor(v*(255-s)/255)
   // ---------------------------------------------------------------------
   s2_type      s2_in, s2_ff;
   logic [31:0] lo_prod;

   always_comb begin
      s2_in.c   = s1_ff.c;
      s2_in.num = NUM_W'(s1_ff.vs) * NUM_W'(s1_ff.k)
                  + NUM_W'(s1_ff.vns) * NUM_W'(HUE_SECTOR);
      lo_prod   = 32'(s1_ff.vns) * 32'(RECIP255);
      s2_in.lo  = lo_prod[RECIP255_SHIFT +: BYTE_W];
   end

   // ---------------------------------------------------------------------
   // Stage 3: divide numerator by 256, then by 15 through a reciprocal
   // ---------------------------------------------------------------------
   s3_type                      s3_in, s3_ff;
   logic [M_W-1:0]              num_m;
   logic [M_W+RECIP15_W-1:0]    q15_prod;

   always_comb begin
      s3_in.c   = s2_ff.c;
      s3_in.lo  = s2_ff.lo;
      num_m     = s2_ff.num[MID_PRE_SHIFT +: M_W];
      q15_prod  = (M_W+RECIP15_W)'(num_m) * (M_W+RECIP15_W)'(RECIP15);
      s3_in.q15 = q15_prod[RECIP15_SHIFT +: Q15_W];
   end

   // ---------------------------------------------------------------------
   // Stage 4: divide by 255, route channels by sector or pass RGB through, blank out-of-area
   // ---------------------------------------------------------------------
   rsp_payload_type   out_ff, out_in;
   logic [31:0]       mid_prod;
   logic [BYTE_W-1:0] mid, lo, hi;
   logic [BYTE_W-1:0] red, green, blue;

   always_comb begin
      mid_prod = 32'(s3_ff.q15) * 32'(RECIP255);
      mid      = mid_prod[RECIP255_SHIFT +: BYTE_W];
      lo       = s3_ff.lo;
      hi       = s3_ff.c.hi;

      case (s3_ff.c.sector)
         SEC_R_G: begin red = hi;  green = mid; blue = lo;  end
         SEC_G_R: begin red = mid; green = hi;  blue = lo;  end
         SEC_G_B: begin red = lo;  green = hi;  blue = mid; end
         SEC_B_G: begin red = lo;  green = mid; blue = hi;  end
         SEC_B_R: begin red = mid; green = lo;  blue = hi;  end
         default: begin red = hi;  green = lo;  blue = mid; end
      endcase

      if (s3_ff.c.action == ACT_RGB) begin
         red   = s3_ff.c.red;
         green = s3_ff.c.green;
         blue  = s3_ff.c.blue;
      end

      if (s3_ff.c.ok) begin
         out_in.write_enable  = 1'b1;
         out_in.write_address = s3_ff.c.addr;
         out_in.red_out       = red;
         out_in.green_out     = green;
         out_in.blue_out      = blue;
      end else begin
         out_in = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Stage registers: valid bits reset, payload holds while stalled
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_bus.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;

endmodule

@@ rtl/core/hsvpw_checker.sv @@
// Checker: port-level assertions for the pixel writer, bound to the top level.
module hsvpw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input hsvpw_pkg::rsp_payload_type  rsp_data
);
   import hsvpw_pkg::*;

   // A rejected pixel carries an all-zero payload
   a_blank_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_enable) |->
         (rsp_data.write_address == '0 && rsp_data.red_out == '0
          && rsp_data.green_out == '0 && rsp_data.blue_out == '0))
      else $error("out-of-area write carries nonzero payload");

   // A stalled response holds valid and payload
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // An open output side never blocks the input side
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // Without stalls an accepted transfer passes every stage and reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted pixel did not reach the output");

endmodule

bind hsv_rgb_pixel_writer_unit hsvpw_checker u_hsvpw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
